[design/clt_pkg.sv]
package clt_pkg;

  // Character classes handed from the front to the scanner
  typedef logic [2:0] cls_t;

  localparam cls_t CL_ZERO   = 3'd0;
  localparam cls_t CL_SPACE  = 3'd1;
  localparam cls_t CL_NPFX   = 3'd2;
  localparam cls_t CL_VPFX   = 3'd3;
  localparam cls_t CL_QUOTE  = 3'd4;
  localparam cls_t CL_LETTER = 3'd5;
  localparam cls_t CL_OTHER  = 3'd6;

  // Character codes
  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_QUOTE = 16'h0022;
  localparam logic [15:0] CH_DASH  = 16'h002D;
  localparam logic [15:0] CH_SLASH = 16'h002F;
  localparam logic [15:0] CH_COLON = 16'h003A;
  localparam logic [15:0] CH_EQUAL = 16'h003D;
  localparam logic [15:0] CH_UA    = 16'h0041;
  localparam logic [15:0] CH_UZ    = 16'h005A;
  localparam logic [15:0] CH_LA    = 16'h0061;
  localparam logic [15:0] CH_LZ    = 16'h007A;

  localparam int CH_W      = 16;
  localparam int POS_W     = 12;
  localparam int EV_W      = 2;
  localparam int MAX_LINE  = 4096;
  localparam int Q_DEPTH   = 2;

  localparam logic [EV_W-1:0] EV_NONE = 2'd0;
  localparam logic [EV_W-1:0] EV_SUB  = 2'd1;
  localparam logic [EV_W-1:0] EV_OPT  = 2'd2;
  localparam logic [EV_W-1:0] EV_OPTV = 2'd3;

  typedef logic [POS_W-1:0] pos_t;

  // One beat leaving the scanner
  typedef struct packed {
    logic [EV_W-1:0] event_res;
    pos_t            name_start;
    pos_t            name_end;
    pos_t            value_start;
    pos_t            value_end;
    logic            line_done;
    logic            line_ok;
  } res_t;

  function automatic cls_t classify(input logic [CH_W-1:0] c);
    cls_t r;
    if (c == '0) begin
      r = CL_ZERO;
    end else if (c == CH_SPACE || c == CH_TAB) begin
      r = CL_SPACE;
    end else if (c == CH_DASH || c == CH_SLASH) begin
      r = CL_NPFX;
    end else if (c == CH_COLON || c == CH_EQUAL) begin
      r = CL_VPFX;
    end else if (c == CH_QUOTE) begin
      r = CL_QUOTE;
    end else if ((c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ)) begin
      r = CL_LETTER;
    end else begin
      r = CL_OTHER;
    end
    return r;
  endfunction

endpackage

[design/command_line_tokenizer_core.sv]
// Path: an accepted character's class is written into the queue, and its result is registered as the output beat.
// Throughput: one character per cycle while the token side is ready; the scanner steps when it pops.
// A two-entry class queue sits between classifier and scanner, so either side stalls alone.
// Reset (rst, synchronous, active high) empties the queue, drops the output beat and
// returns the scanner to the start of a new line at position 0 with no error.
module command_line_tokenizer_core #(
  parameter int MAX_LINE = clt_pkg::MAX_LINE
) (
  input  logic        clk,
  input  logic        rst,
  // Character stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] ch
  // Token stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [11:0] name_start, [23:12] name_end,
                                      // [35:24] value_start, [47:36] value_end
  output logic        m_axis_tlast,   // line_done: beat of the terminating zero
  output logic [7:0]  m_axis_tuser    // [1:0] event_res, [2] line_ok, rest zero
);
  import clt_pkg::*;

  logic push;
  cls_t push_cls;
  logic q_full;
  logic q_valid;
  cls_t q_cls;
  logic pop;
  res_t res;

  // Front: classify each character beat and push its class
  clt_front u_front (
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_ch    (s_axis_tdata),
    .push     (push),
    .push_cls (push_cls),
    .q_full   (q_full)
  );

  // Hold classes until the scanner takes them
  clt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cls (push_cls),
    .full     (q_full),
    .valid    (q_valid),
    .head_cls (q_cls),
    .pop      (pop)
  );

  // Back: advance the scanner and register one result per character
  clt_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cls     (q_cls),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {res.value_end, res.value_start, res.name_end, res.name_start};
  assign m_axis_tlast = res.line_done;
  assign m_axis_tuser = {5'b0, res.line_ok, res.event_res};

endmodule

[design/clt_front.sv]
module clt_front (
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [clt_pkg::CH_W-1:0]      in_ch,
  output logic                          push,
  output clt_pkg::cls_t                 push_cls,
  input  logic                          q_full
);
  import clt_pkg::*;

  logic accepted;

  // Classify on the way in; only the class travels on
  assign in_ready = !q_full && !rst;
  assign accepted = in_valid && in_ready;
  assign push     = accepted;
  assign push_cls = classify(in_ch);

endmodule

[design/clt_queue.sv]
module clt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  clt_pkg::cls_t push_cls,
  output logic          full,
  output logic          valid,
  output clt_pkg::cls_t head_cls,
  input  logic          pop
);
  import clt_pkg::*;

  localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  cls_t          mem [Q_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(Q_DEPTH));
  assign valid    = (count != '0);
  assign head_cls = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/clt_back.sv]
module clt_back #(
  parameter int MAX_LINE = clt_pkg::MAX_LINE
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  clt_pkg::cls_t q_cls,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output clt_pkg::res_t out_res
);
  import clt_pkg::*;

  localparam logic [2:0] M_NEW   = 3'd0;
  localparam logic [2:0] M_WHITE = 3'd1;
  localparam logic [2:0] M_SUB   = 3'd2;
  localparam logic [2:0] M_PFX   = 3'd3;
  localparam logic [2:0] M_NAME  = 3'd4;
  localparam logic [2:0] M_VPFX  = 3'd5;
  localparam logic [2:0] M_VAL   = 3'd6;
  localparam logic [2:0] M_ERR   = 3'd7;

  localparam logic [31:0] LIMIT = 32'(MAX_LINE - 1);

  logic [2:0] mode, mode_next;
  logic       in_quote, in_quote_next;
  pos_t       position, position_next;
  pos_t       token_start, token_start_next;
  pos_t       name_stop, name_stop_next;
  pos_t       value_begin, value_begin_next;
  logic       failed, failed_next;
  res_t       res_next;

  logic bad;
  logic white;
  logic is_zero;

  assign pop     = q_valid && (!out_valid || out_ready);
  assign is_zero = (q_cls == CL_ZERO);
  assign white   = is_zero || (q_cls == CL_SPACE);

  always_comb begin
    mode_next        = mode;
    in_quote_next    = in_quote;
    token_start_next = token_start;
    name_stop_next   = name_stop;
    value_begin_next = value_begin;
    failed_next      = failed;
    position_next    = position;
    res_next         = '0;
    bad              = !is_zero && ({{(32-POS_W){1'b0}}, position} >= LIMIT);

    if (!bad) begin
      case (mode)
        M_NEW, M_WHITE: begin
          if (mode == M_NEW) begin
            in_quote_next = 1'b0;
          end
          if (white) begin
            mode_next = M_WHITE;
          end else if (q_cls == CL_NPFX) begin
            mode_next = M_PFX;
          end else if (q_cls == CL_LETTER) begin
            token_start_next = position;
            mode_next        = M_SUB;
          end else if (q_cls == CL_QUOTE) begin
            in_quote_next = 1'b1;
            mode_next     = M_WHITE;
          end else begin
            bad = 1'b1;
          end
        end
        M_SUB: begin
          if (white || q_cls == CL_QUOTE) begin
            res_next.event_res  = EV_SUB;
            res_next.name_start = token_start;
            res_next.name_end   = position;
            mode_next           = M_NEW;
          end else if (q_cls != CL_LETTER) begin
            bad = 1'b1;
          end
        end
        M_PFX: begin
          if (white) begin
            bad = 1'b1;
          end else if (q_cls != CL_NPFX) begin
            token_start_next = position;
            mode_next        = M_NAME;
          end
        end
        M_NAME: begin
          if (white || q_cls == CL_QUOTE) begin
            res_next.event_res  = EV_OPT;
            res_next.name_start = token_start;
            res_next.name_end   = position;
            mode_next           = M_NEW;
          end else if (q_cls == CL_VPFX) begin
            name_stop_next = position;
            mode_next      = M_VPFX;
          end
        end
        M_VPFX: begin
          if (white) begin
            if (in_quote) begin
              value_begin_next = position;
              mode_next        = M_VAL;
            end else begin
              res_next.event_res  = EV_OPT;
              res_next.name_start = token_start;
              res_next.name_end   = name_stop;
              mode_next           = M_NEW;
            end
          end else if (q_cls == CL_QUOTE) begin
            value_begin_next = position + 1'b1;
            in_quote_next    = 1'b1;
          end else begin
            value_begin_next = position;
            mode_next        = M_VAL;
          end
        end
        M_VAL: begin
          if ((white && !in_quote) || q_cls == CL_QUOTE) begin
            res_next.event_res   = EV_OPTV;
            res_next.name_start  = token_start;
            res_next.name_end    = name_stop;
            res_next.value_start = value_begin;
            res_next.value_end   = position;
            mode_next            = M_NEW;
          end
        end
        default: begin
          mode_next = mode;
        end
      endcase
    end

    if (bad) begin
      res_next    = '0;
      failed_next = 1'b1;
      mode_next   = M_ERR;
    end

    if (is_zero) begin
      res_next.line_done = 1'b1;
      res_next.line_ok   = !failed_next;
      mode_next          = M_NEW;
      in_quote_next      = 1'b0;
      position_next      = '0;
      token_start_next   = '0;
      name_stop_next     = '0;
      value_begin_next   = '0;
      failed_next        = 1'b0;
    end else if (mode_next != M_ERR) begin
      position_next = position + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_NEW;
      in_quote    <= 1'b0;
      position    <= '0;
      token_start <= '0;
      name_stop   <= '0;
      value_begin <= '0;
      failed      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        mode        <= mode_next;
        in_quote    <= in_quote_next;
        position    <= position_next;
        token_start <= token_start_next;
        name_stop   <= name_stop_next;
        value_begin <= value_begin_next;
        failed      <= failed_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= res_next;
    end
  end

endmodule

[tb/tb_command_line_tokenizer_core.sv]
`timescale 1ns / 1ps

module tb_command_line_tokenizer_core;
  import clt_pkg::*;

  // Scanner modes of the predictor; error mode holds until the terminating zero
  typedef enum logic [2:0] {
    SM_NEW, SM_WHITE, SM_SUB, SM_PFX, SM_NAME, SM_VPFX, SM_VAL, SM_ERR
  } scan_mode_e;

  // Predicts one token beat per character beat and checks the beats that leave the block
  class token_scoreboard;
    scan_mode_e mode;
    bit         quoted;
    pos_t       position;
    pos_t       tok_start;
    pos_t       name_stop;
    pos_t       val_begin;
    bit         failed;
    res_t       pending[$];
    int         mismatches;
    int         beats;

    function new();
      reset_line();
      mismatches = 0;
      beats = 0;
    endfunction

    function void reset_line();
      mode      = SM_NEW;
      quoted    = 1'b0;
      position  = '0;
      tok_start = '0;
      name_stop = '0;
      val_begin = '0;
      failed    = 1'b0;
    endfunction

    function bit is_space(logic [15:0] c);
      return c == 16'h0000 || c == CH_SPACE || c == CH_TAB;
    endfunction

    function bit is_name_pfx(logic [15:0] c);
      return c == CH_DASH || c == CH_SLASH;
    endfunction

    function bit is_letter(logic [15:0] c);
      return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    // Advance the scanner by one accepted character and queue the beat it causes
    function void note_char(logic [15:0] c);
      pos_t p;
      res_t r;
      bit   bad;
      p   = position;
      r   = '0;
      bad = (c != 16'h0000) && (int'(p) >= MAX_LINE - 1);
      if (!bad) begin
        case (mode)
          SM_NEW, SM_WHITE: begin
            if (mode == SM_NEW) quoted = 1'b0;
            if (is_space(c)) begin
              mode = SM_WHITE;
            end else if (is_name_pfx(c)) begin
              mode = SM_PFX;
            end else if (is_letter(c)) begin
              tok_start = p;
              mode = SM_SUB;
            end else if (c == CH_QUOTE) begin
              quoted = 1'b1;
              mode = SM_WHITE;
            end else begin
              bad = 1'b1;
            end
          end
          SM_SUB: begin
            if (is_space(c) || c == CH_QUOTE) begin
              r.event_res  = EV_SUB;
              r.name_start = tok_start;
              r.name_end   = p;
              mode = SM_NEW;
            end else if (!is_letter(c)) begin
              bad = 1'b1;
            end
          end
          SM_PFX: begin
            if (is_space(c)) begin
              bad = 1'b1;
            end else if (!is_name_pfx(c)) begin
              tok_start = p;
              mode = SM_NAME;
            end
          end
          SM_NAME: begin
            if (is_space(c) || c == CH_QUOTE) begin
              r.event_res  = EV_OPT;
              r.name_start = tok_start;
              r.name_end   = p;
              mode = SM_NEW;
            end else if (c == CH_COLON || c == CH_EQUAL) begin
              name_stop = p;
              mode = SM_VPFX;
            end
          end
          SM_VPFX: begin
            if (is_space(c)) begin
              if (quoted) begin
                val_begin = p;
                mode = SM_VAL;
              end else begin
                r.event_res  = EV_OPT;
                r.name_start = tok_start;
                r.name_end   = name_stop;
                mode = SM_NEW;
              end
            end else if (c == CH_QUOTE) begin
              // value starts after the opening quote
              val_begin = p + 12'd1;
              quoted = 1'b1;
            end else begin
              val_begin = p;
              mode = SM_VAL;
            end
          end
          SM_VAL: begin
            if ((is_space(c) && !quoted) || c == CH_QUOTE) begin
              r.event_res   = EV_OPTV;
              r.name_start  = tok_start;
              r.name_end    = name_stop;
              r.value_start = val_begin;
              r.value_end   = p;
              mode = SM_NEW;
            end
          end
          default: ;
        endcase
      end
      if (bad) begin
        r = '0;
        failed = 1'b1;
        mode = SM_ERR;
      end
      if (c == 16'h0000) begin
        r.line_done = 1'b1;
        r.line_ok   = !failed;
        reset_line();
      end else if (mode != SM_ERR) begin
        position = p + 12'd1;
      end
      pending.push_back(r);
    endfunction

    function void flag(string what, res_t e, res_t g, logic [7:0] u);
      if (mismatches < 10)
        $display("%0t beat %0d %s: exp ev=%0d name=%0d..%0d val=%0d..%0d done=%0d ok=%0d",
                 $realtime, beats, what, e.event_res, e.name_start, e.name_end,
                 e.value_start, e.value_end, e.line_done, e.line_ok,
                 "\n  got ev=%0d name=%0d..%0d val=%0d..%0d done=%0d ok=%0d tuser=%h",
                 g.event_res, g.name_start, g.name_end, g.value_start, g.value_end,
                 g.line_done, g.line_ok, u);
      mismatches++;
    endfunction

    // Compare one accepted token beat with the oldest pending prediction
    function void check_beat(logic [47:0] d, logic last, logic [7:0] u);
      res_t got;
      res_t want;
      got.event_res   = u[1:0];
      got.line_ok     = u[2];
      got.line_done   = last;
      got.name_start  = d[11:0];
      got.name_end    = d[23:12];
      got.value_start = d[35:24];
      got.value_end   = d[47:36];
      if (pending.size() == 0) begin
        flag("with nothing pending", '0, got, u);
      end else begin
        want = pending.pop_front();
        if (got !== want || u[7:3] !== 5'd0) flag("mismatch", want, got, u);
      end
      beats++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [7:0]  m_axis_tuser;

  token_scoreboard sb;
  int          send_idle_pct = 0;   // chance per cycle that the character side holds off
  int          recv_stall_pct = 0;  // chance per cycle that the token side stalls
  int          chars_sent = 0;
  logic [15:0] line_buf[$];

  command_line_tokenizer_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Token side: check every accepted beat, then roll the stall for the next cycle
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Drive one character beat: random hold-off, then hold valid until accepted
  task automatic send_char(logic [15:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_char(c);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_char({8'h00, s[i]});
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i]);
  endtask

  // Drop valid and wait until every predicted beat has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_letter();
    return ($urandom_range(1) ? CH_UA : CH_LA) + 16'($urandom_range(25));
  endfunction

  function automatic logic [15:0] pick_space();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  // Any character that neither ends a name nor opens a value
  function automatic logic [15:0] pick_name_char();
    logic [15:0] c;
    case ($urandom_range(3))
      0: c = pick_letter();
      1: c = 16'h0030 + 16'($urandom_range(9));
      2: c = $urandom_range(1) ? 16'h005F : 16'h002E;
      default: c = 16'($urandom_range(16'h0080, 16'hFFFF));
    endcase
    return c;
  endfunction

  function automatic logic [15:0] pick_any_nonzero();
    logic [15:0] specials[9];
    specials = '{CH_SPACE, CH_TAB, CH_QUOTE, CH_DASH, CH_SLASH, CH_COLON, CH_EQUAL,
                 CH_UZ, CH_LA};
    if ($urandom_range(1)) return 16'($urandom_range(1, 16'hFFFF));
    return specials[$urandom_range(8)];
  endfunction

  function automatic void add_separator();
    if ($urandom_range(99) < 15) begin
      line_buf.push_back(CH_QUOTE);
    end else begin
      repeat ($urandom_range(1, 2)) line_buf.push_back(pick_space());
    end
  endfunction

  // Mostly well-formed lines of subcommands and options; the rest noise or broken
  function automatic void build_line();
    int shape;
    int cut;
    line_buf = {};
    shape = $urandom_range(99);
    if (shape < 20) begin
      repeat ($urandom_range(1, 12)) line_buf.push_back(pick_any_nonzero());
    end else begin
      if ($urandom_range(9) == 0) line_buf.push_back(CH_QUOTE);
      repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(2))
          0: repeat ($urandom_range(1, 6)) line_buf.push_back(pick_letter());
          default: begin
            line_buf.push_back($urandom_range(1) ? CH_DASH : CH_SLASH);
            if ($urandom_range(4) == 0) line_buf.push_back(CH_DASH);
            repeat ($urandom_range(1, 5)) line_buf.push_back(pick_name_char());
            if ($urandom_range(1)) begin
              line_buf.push_back($urandom_range(1) ? CH_COLON : CH_EQUAL);
              if ($urandom_range(2) == 0) begin
                line_buf.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 5))
                  line_buf.push_back($urandom_range(2) == 0 ? pick_space()
                                                            : pick_name_char());
                if ($urandom_range(5) != 0) line_buf.push_back(CH_QUOTE);
              end else begin
                repeat ($urandom_range(0, 4)) line_buf.push_back(pick_name_char());
              end
            end
          end
        endcase
        add_separator();
      end
      // break some lines: cut them short or plant a stray character
      if (shape < 30) begin
        cut = $urandom_range(line_buf.size() - 1);
        while (line_buf.size() > cut + 1) void'(line_buf.pop_back());
      end else if (shape < 38) begin
        line_buf.insert($urandom_range(line_buf.size()), pick_any_nonzero());
      end
    end
    line_buf.push_back(16'h0000);
  endfunction

  // A line of short subcommands with the given number of characters before the zero
  function automatic void build_long_line(int len);
    line_buf = {};
    for (int i = 0; i < len; i++)
      line_buf.push_back((i % 7 == 6) ? pick_space() : pick_letter());
    line_buf.push_back(16'h0000);
  endfunction

  // Give up if the run hangs
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int phase_start;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed lines: every token kind, both prefixes of each sort, a quoted value,
    // an error at the terminator, an illegal character and an unterminated quote
    send_text("Zz -a:b /c");
    send_char(16'h0000);
    send_text("-n:\" \"");
    send_char(16'h0000);
    send_text("-");
    send_char(16'h0000);
    send_char(CH_UA);
    send_char(16'hFFFF);
    send_char(16'h0000);
    send_text("-k=\"");
    send_char(16'h0000);

    // Random phases; stop sending and let everything drain between them
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      if (ph == 0) begin
        // longest legal line, then one that runs past the limit
        build_long_line(MAX_LINE - 1);
        send_line();
        build_long_line(MAX_LINE + 4);
        send_line();
      end
      phase_start = chars_sent;
      while (chars_sent - phase_start < 190) begin
        build_line();
        send_line();
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
